// File: src/rhsl_pkg.sv
package rhsl_pkg;

	// field widths
	localparam int unsigned CH_W  = 8;
	localparam int unsigned NUM_W = 24;
	localparam int unsigned DEN_W = 8;
	localparam int unsigned QUO_W = 16;

	// one pixel word in, one hsl word out
	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [QUO_W-1:0] hue;
		logic [QUO_W-1:0] saturation;
		logic [QUO_W-1:0] lightness;
	} hsl_t;

	// largest channel, red wins ties, then green
	typedef enum logic [2:0] {
		SECT_RED   = 3'b001,
		SECT_GREEN = 3'b010,
		SECT_BLUE  = 3'b100
	} sector_t;

	// front end to divider bank
	typedef struct packed {
		logic             valid;
		logic             grey;
		logic [NUM_W-1:0] hue_num;
		logic [DEN_W-1:0] hue_den;
		logic [NUM_W-1:0] sat_num;
		logic [DEN_W-1:0] sat_den;
		logic [NUM_W-1:0] light_num;
	} div_req_t;

	// constants of the conversion
	localparam logic [QUO_W-1:0] HUE_FULL   = 16'd46080;
	localparam logic [QUO_W-1:0] Q15_ONE    = 16'd32768;
	localparam logic [DEN_W-1:0] LIGHT_DEN  = 8'd255;
	localparam logic [NUM_W-1:0] LIGHT_BIAS = 24'd127;
	localparam int unsigned      DIV_LAT    = 4;

endpackage

// File: src/rgb_to_hsl_converter_core.sv
// channel   dir  signals                       handshake
// pixel     in   pixel{red,green,blue}         start high, busy low
// result    out  result{hue,saturation,light}  done strobe, one cycle
//
// one pixel per clock, with no stall between start and done
// latency is the front end (3 stages) plus the reciprocal dividers (4) and the output stage
// busy is never raised; results cannot be held off by the receiver
// arst_n clears the valid bits only; data registers are not reset
module rgb_to_hsl_converter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rhsl_pkg::pixel_t pixel,
	output logic             busy,
	output logic             done,
	output rhsl_pkg::hsl_t   result
);
	import rhsl_pkg::*;

	div_req_t         req;
	logic [QUO_W-1:0] hue_quo, sat_quo, light_quo;
	logic [QUO_W-1:0] hue_wrap;

	logic v_s4, v_s5, v_s6, v_s7, v_s8;
	logic g_s4, g_s5, g_s6, g_s7;
	hsl_t res_s8;

	assign busy = 1'b0;

	rhsl_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.pixel  (pixel),
		.req    (req)
	);

	rhsl_div u_hue_div (
		.clk (clk),
		.num (req.hue_num),
		.den (req.hue_den),
		.quo (hue_quo)
	);

	rhsl_div u_sat_div (
		.clk (clk),
		.num (req.sat_num),
		.den (req.sat_den),
		.quo (sat_quo)
	);

	rhsl_div u_light_div (
		.clk (clk),
		.num (req.light_num),
		.den (LIGHT_DEN),
		.quo (light_quo)
	);

	// valid bits alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s4 <= req.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// grey flag alongside the dividers
	always_ff @(posedge clk) begin
		g_s4 <= req.grey;
		g_s5 <= g_s4;
		g_s6 <= g_s5;
		g_s7 <= g_s6;
	end

	// hue wraps once past a full turn
	assign hue_wrap = (hue_quo >= HUE_FULL) ? hue_quo - HUE_FULL : hue_quo;

	// output word, grey pixels have no hue or saturation
	always_ff @(posedge clk) begin
		res_s8.hue        <= g_s7 ? '0 : hue_wrap;
		res_s8.saturation <= g_s7 ? '0 : sat_quo;
		res_s8.lightness  <= light_quo;
	end

	assign done   = v_s8;
	assign result = res_s8;

`ifndef NO_ASSERTIONS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DIV_LAT + 4))
		else $error("result word without a matching pixel word");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hue < HUE_FULL))
		else $error("hue not wrapped");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturation == '0) |-> (result.hue == '0))
		else $error("grey pixel with nonzero hue");

	a_q15_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.saturation <= Q15_ONE && result.lightness <= Q15_ONE))
		else $error("q15 value above one");
`endif

endmodule

// File: src/rhsl_front.sv
module rhsl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rhsl_pkg::pixel_t  pixel,
	output rhsl_pkg::div_req_t req
);
	import rhsl_pkg::*;

	logic [CH_W-1:0] mx, mn;
	sector_t         sect;

	logic            v_s1, v_s2, v_s3;
	logic [CH_W-1:0] red_s1, green_s1, blue_s1, mx_s1, mn_s1;
	sector_t         sect_s1;

	logic [CH_W-1:0] c_s2, den_s2;
	logic [8:0]      sum_s2;
	logic [10:0]     num_s2;

	logic [CH_W-1:0] c2;
	logic [8:0]      sum2;
	logic [10:0]     c6, c2x, c4;

	logic             grey_s3;
	logic [NUM_W-1:0] hue_num_s3;
	logic [DEN_W-1:0] hue_den_s3;
	logic [NUM_W-1:0] sat_num_s3;
	logic [DEN_W-1:0] sat_den_s3;
	logic [NUM_W-1:0] light_num_s3;

	// max, min and sector of the pixel
	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		if (pixel.red == mx) begin
			sect = SECT_RED;
		end else if (pixel.green == mx) begin
			sect = SECT_GREEN;
		end else begin
			sect = SECT_BLUE;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		red_s1   <= pixel.red;
		green_s1 <= pixel.green;
		blue_s1  <= pixel.blue;
		mx_s1    <= mx;
		mn_s1    <= mn;
		sect_s1  <= sect;
	end

	// chroma, sum and multiples of chroma
	always_comb begin
		c2   = mx_s1 - mn_s1;
		sum2 = {1'b0, mx_s1} + {1'b0, mn_s1};
		c2x  = {2'b0, c2, 1'b0};
		c4   = {1'b0, c2, 2'b0};
		c6   = c4 + c2x;
	end

	// hue numerator diff + k*c
	always_ff @(posedge clk) begin
		c_s2   <= c2;
		sum_s2 <= sum2;
		den_s2 <= (sum2 <= 9'd255) ? sum2[7:0] : 8'(9'd510 - sum2);
		case (sect_s1)
			SECT_RED:   num_s2 <= c6 + {3'b0, green_s1} - {3'b0, blue_s1};
			SECT_GREEN: num_s2 <= c2x + {3'b0, blue_s1} - {3'b0, red_s1};
			SECT_BLUE:  num_s2 <= c4 + {3'b0, red_s1} - {3'b0, green_s1};
			default:    num_s2 <= '0;
		endcase
	end

	// scaled numerators with half-divisor rounding bias
	always_ff @(posedge clk) begin
		grey_s3      <= (c_s2 == '0);
		hue_num_s3   <= {num_s2, 13'b0} - {4'b0, num_s2, 9'b0} + {17'b0, c_s2[7:1]};
		hue_den_s3   <= c_s2;
		sat_num_s3   <= {1'b0, c_s2, 15'b0} + {17'b0, den_s2[7:1]};
		sat_den_s3   <= den_s2;
		light_num_s3 <= {1'b0, sum_s2, 14'b0} + LIGHT_BIAS;
	end

	always_comb begin
		req.valid     = v_s3;
		req.grey      = grey_s3;
		req.hue_num   = hue_num_s3;
		req.hue_den   = hue_den_s3;
		req.sat_num   = sat_num_s3;
		req.sat_den   = sat_den_s3;
		req.light_num = light_num_s3;
	end

endmodule

// File: src/rhsl_div.sv
module rhsl_div (
	input  logic                          clk,
	input  logic [rhsl_pkg::NUM_W-1:0]    num,
	input  logic [rhsl_pkg::DEN_W-1:0]    den,
	output logic [rhsl_pkg::QUO_W-1:0]    quo
);
	import rhsl_pkg::*;

	localparam int unsigned RCP_W = NUM_W + 1;
	localparam int unsigned Q0_W  = QUO_W + 1;
	localparam int unsigned QD_W  = Q0_W + DEN_W;

	logic [RCP_W-1:0] recip [1 << DEN_W];

	logic [NUM_W-1:0]       num_s1, num_s2, num_s3;
	logic [DEN_W-1:0]       den_s1, den_s2, den_s3;
	logic [RCP_W-1:0]       rcp_s1;
	logic [NUM_W+RCP_W-1:0] prod;
	logic [Q0_W-1:0]        q0_s2, q0_s3, quo_s4;
	logic [QD_W-1:0]        qd_s3;
	logic [NUM_W-1:0]       rem;

	// reciprocal table, floor(2^NUM_W / d), zero for d = 0
	for (genvar i = 0; i < (1 << DEN_W); i++) begin : g_recip
		localparam logic [RCP_W-1:0] RV =
			(i == 0) ? '0 : RCP_W'((1 << NUM_W) / ((i == 0) ? 1 : i));
		assign recip[i] = RV;
	end

	// reciprocal lookup
	always_ff @(posedge clk) begin
		num_s1 <= num;
		den_s1 <= den;
		rcp_s1 <= recip[den];
	end

	// estimate, low by at most one
	assign prod = num_s1 * rcp_s1;

	always_ff @(posedge clk) begin
		q0_s2  <= prod[NUM_W +: Q0_W];
		num_s2 <= num_s1;
		den_s2 <= den_s1;
	end

	// back-multiply the estimate
	always_ff @(posedge clk) begin
		qd_s3  <= q0_s2 * den_s2;
		q0_s3  <= q0_s2;
		num_s3 <= num_s2;
		den_s3 <= den_s2;
	end

	// one correction step
	assign rem = num_s3 - qd_s3[NUM_W-1:0];

	always_ff @(posedge clk) begin
		quo_s4 <= (rem >= {{(NUM_W-DEN_W){1'b0}}, den_s3}) ? q0_s3 + 1'b1 : q0_s3;
	end

	assign quo = quo_s4[QUO_W-1:0];

endmodule

// File: test/rgb_to_hsl_converter_core_tb.sv
module rgb_to_hsl_converter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rhsl_pkg::*;

	localparam int unsigned RANDOM_WORDS = 1400;
	localparam int unsigned TAIL_CYCLES  = 24;

	logic   clk;
	logic   arst_n;
	logic   start = 1'b0;
	pixel_t pixel = '0;
	logic   busy;
	logic   done;
	hsl_t   result;

	// pixels waiting to be sent, hsl words waiting to come back
	pixel_t pixel_queue[$];
	hsl_t   expected_hsl[$];

	int unsigned total_words;
	int unsigned words_in = 0;
	int unsigned words_checked = 0;
	int unsigned grey_words = 0;
	int unsigned mismatches = 0;
	bit          word_taken = 1'b0;

	rgb_to_hsl_converter_core i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.pixel (pixel),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	// round to nearest, halves up, zero denominator gives zero
	function automatic int unsigned round_quot(int unsigned num, int unsigned den);
		if (den == 0)
			return 0;
		return (2 * num + den) / (2 * den);
	endfunction

	// hue, saturation and lightness of one pixel
	function automatic hsl_t predict_hsl(pixel_t px);
		int unsigned r;
		int unsigned g;
		int unsigned b;
		int unsigned hi;
		int unsigned lo;
		int unsigned chroma;
		int unsigned sum;
		int unsigned den;
		int unsigned num;
		int unsigned hue_val;
		hsl_t        word;
		r = px.red;
		g = px.green;
		b = px.blue;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		chroma = hi - lo;
		sum = hi + lo;
		word.lightness = QUO_W'(round_quot(sum * 32768, 510));
		word.hue = '0;
		word.saturation = '0;
		if (chroma != 0) begin
			// sector by largest channel, red wins ties, then green
			if (r == hi)
				num = 6 * chroma + g - b;
			else if (g == hi)
				num = 2 * chroma + b - r;
			else
				num = 4 * chroma + r - g;
			hue_val = round_quot(num * 7680, chroma);
			if (hue_val >= 46080)
				hue_val = hue_val - 46080;
			word.hue = QUO_W'(hue_val);
			den = (sum <= 255) ? sum : (510 - sum);
			word.saturation = QUO_W'(round_quot(chroma * 32768, den));
		end
		return word;
	endfunction

	function automatic pixel_t make_pixel(int unsigned r, int unsigned g, int unsigned b);
		pixel_t px;
		px.red = CH_W'(r);
		px.green = CH_W'(g);
		px.blue = CH_W'(b);
		return px;
	endfunction

	// channel value biased to the ends of the range
	function automatic int unsigned edge_channel();
		int unsigned pick;
		pick = $urandom_range(0, 3);
		case (pick)
			0: return 0;
			1: return 1;
			2: return 254;
			default: return 255;
		endcase
	endfunction

	task automatic compare_field(string field, logic [QUO_W-1:0] want, logic [QUO_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// sender: present the next word at the falling edge
	always @(negedge clk) begin : pixel_driver
		int unsigned idle_pct;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || word_taken) begin
			if (words_in < total_words / 3)
				idle_pct = 32;
			else if (words_in < 2 * total_words / 3)
				idle_pct = 48;
			else
				idle_pct = 0;
			if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				pixel <= pixel_queue.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// receiver: check results, then record the word taken at this edge
	always @(posedge clk) begin : result_monitor
		hsl_t want;
		if (!arst_n) begin
			word_taken = 1'b0;
		end else begin
			if (done === 1'b1) begin
				if (expected_hsl.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no word pending, actual %0d %0d %0d",
						$time, result.hue, result.saturation, result.lightness);
				end else begin
					want = expected_hsl.pop_front();
					compare_field("hue", want.hue, result.hue);
					compare_field("saturation", want.saturation, result.saturation);
					compare_field("lightness", want.lightness, result.lightness);
					words_checked++;
				end
			end
			word_taken = start && !busy;
			if (word_taken) begin
				expected_hsl.push_back(predict_hsl(pixel));
				if (pixel.red == pixel.green && pixel.green == pixel.blue)
					grey_words++;
				words_in++;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned kind;
		int unsigned v;
		int unsigned w;
		arst_n = 1'b0;

		// directed: extremes, each sector, ties, grey, full saturation
		pixel_queue.push_back(make_pixel(0, 0, 0));
		pixel_queue.push_back(make_pixel(255, 255, 255));
		pixel_queue.push_back(make_pixel(128, 128, 128));
		pixel_queue.push_back(make_pixel(255, 0, 0));
		pixel_queue.push_back(make_pixel(0, 255, 0));
		pixel_queue.push_back(make_pixel(0, 0, 255));
		pixel_queue.push_back(make_pixel(255, 255, 0));
		pixel_queue.push_back(make_pixel(0, 255, 255));
		pixel_queue.push_back(make_pixel(255, 0, 255));
		pixel_queue.push_back(make_pixel(200, 200, 100));
		pixel_queue.push_back(make_pixel(100, 200, 200));
		pixel_queue.push_back(make_pixel(200, 100, 200));
		// hue at or just under a full turn
		pixel_queue.push_back(make_pixel(255, 0, 1));
		pixel_queue.push_back(make_pixel(1, 0, 0));
		pixel_queue.push_back(make_pixel(2, 0, 1));
		// near white, smallest saturation denominator
		pixel_queue.push_back(make_pixel(255, 254, 254));
		pixel_queue.push_back(make_pixel(254, 255, 254));
		pixel_queue.push_back(make_pixel(254, 254, 255));
		pixel_queue.push_back(make_pixel(0, 0, 1));
		pixel_queue.push_back(make_pixel(0, 1, 0));
		pixel_queue.push_back(make_pixel(127, 128, 0));
		pixel_queue.push_back(make_pixel(128, 127, 255));
		pixel_queue.push_back(make_pixel(85, 170, 255));

		// random part, with extra weight on grey, ties and range ends
		repeat (RANDOM_WORDS) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: begin
					v = $urandom_range(0, 255);
					pixel_queue.push_back(make_pixel(v, v, v));
				end
				1: begin
					v = $urandom_range(0, 255);
					w = $urandom_range(0, 255);
					case ($urandom_range(0, 2))
						0: pixel_queue.push_back(make_pixel(v, v, w));
						1: pixel_queue.push_back(make_pixel(w, v, v));
						default: pixel_queue.push_back(make_pixel(v, w, v));
					endcase
				end
				2: pixel_queue.push_back(make_pixel(edge_channel(), edge_channel(),
					edge_channel()));
				default: pixel_queue.push_back(make_pixel($urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255)));
			endcase
		end
		total_words = pixel_queue.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (words_in == total_words);
		wait (expected_hsl.size() == 0);
		// nothing more should come out of the pipeline
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("converted %0d pixels (%0d grey), %0d results checked, %0d mismatches",
			words_in, grey_words, words_checked, mismatches);
		$display("sender idled 32%% then 48%% then not at all, one word per clock at most");
		if (mismatches == 0 && expected_hsl.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
